### rtl/core/square_wave_tone_channel_unit_defines.svh
// Assertion helpers for the tone channel, clocked on aclk, off during reset.
`ifndef SQUARE_WAVE_TONE_CHANNEL_UNIT_DEFINES_SVH
`define SQUARE_WAVE_TONE_CHANNEL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/swt_pkg.sv
package swt_pkg;

    typedef enum logic [2:0] {
        ACT_WRITE   = 3'd0,
        ACT_TICK    = 3'd1,
        ACT_QUARTER = 3'd2,
        ACT_HALF    = 3'd3,
        ACT_ENABLE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_CTRL  = 2'd0,
        REG_SWEEP = 2'd1,
        REG_LO    = 2'd2,
        REG_HI    = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic enabled;
        logic env_start;
        logic negate;
        logic sweep_reload;
        logic sweep_en;
        logic const_vol;
        logic halt;
    } ctrl_flags_t;

    localparam logic [10:0] PERIOD_MAX = 11'h7FF;
    localparam logic [10:0] PERIOD_MIN = 11'd8;
    localparam logic [3:0]  ENV_TOP    = 4'hF;

    localparam logic [7:0] DUTY_TABLE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    localparam logic [7:0] LENGTH_TABLE [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

endpackage

### rtl/core/square_wave_tone_channel_unit.sv
// An accepted transaction waits in the input register; when it advances (result register
// empty or m_axis_tready), the result register loads and the result is on m_axis.
// Throughput: one transaction per cycle unless m_axis stalls; input and result stages
// with a short state-update path between, channel state written as the result loads.
// Reset: aresetn is synchronous, active low; clears handshake state, channel state
// (envelope level to 15) and the negate-mode register. Payload registers are not reset.
module square_wave_tone_channel_unit
    import swt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: first_channel_negate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    // Input transactions
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [1:0] reg_index, [9:2] write_value,
                                       // [10] enable_value, [15:11] zero
    input  logic [2:0]  s_axis_tuser,  // [2:0] action

    // Result transactions
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [3:0] level, [4] length_active,
                                       // [5] channel_on, [7:6] zero
);

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic        in_valid_reg;
    logic [2:0]  in_action_reg;
    logic [1:0]  in_index_reg;
    logic [7:0]  in_wval_reg;
    logic        in_en_reg;

    logic        out_valid_reg;
    logic [3:0]  out_level_reg;
    logic        out_length_reg;
    logic        out_on_reg;

    logic        advance;   // input stage item is processed this cycle
    logic        s_fire;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_on_reg, out_length_reg, out_level_reg};

    // The user changes config only while idle (the block does not enforce it), so it needs no back-pressure.
    assign cfg_ready = 1'b1;

    logic negate_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            negate_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            negate_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_action_reg <= s_axis_tuser;
            in_index_reg  <= s_axis_tdata[1:0];
            in_wval_reg   <= s_axis_tdata[9:2];
            in_en_reg     <= s_axis_tdata[10];
        end
    end

    // ---------------------------------------------------------------
    // Channel state
    // ---------------------------------------------------------------
    logic [10:0] countdown_reg,  countdown_next;
    logic [10:0] period_reg,     period_next;
    logic [2:0]  duty_step_reg,  duty_step_next;
    logic [1:0]  duty_sel_reg,   duty_sel_next;
    logic [7:0]  length_reg,     length_next;
    logic [3:0]  volume_reg,     volume_next;
    logic [3:0]  env_div_reg,    env_div_next;
    logic [3:0]  env_level_reg,  env_level_next;
    logic [2:0]  sw_shift_reg,   sw_shift_next;
    logic [2:0]  sw_period_reg,  sw_period_next;
    logic [2:0]  sw_div_reg,     sw_div_next;
    ctrl_flags_t flags_reg,      flags_next;

    always_comb begin
        logic [10:0] change;
        logic [11:0] target;
        logic [10:0] dec;

        countdown_next = countdown_reg;
        period_next    = period_reg;
        duty_step_next = duty_step_reg;
        duty_sel_next  = duty_sel_reg;
        length_next    = length_reg;
        volume_next    = volume_reg;
        env_div_next   = env_div_reg;
        env_level_next = env_level_reg;
        sw_shift_next  = sw_shift_reg;
        sw_period_next = sw_period_reg;
        sw_div_next    = sw_div_reg;
        flags_next     = flags_reg;

        change = period_reg >> sw_shift_reg;
        target = {1'b0, period_reg} + {1'b0, change};
        dec    = change + {10'd0, negate_mode_reg};

        if (advance) begin
            unique case (action_t'(in_action_reg))
                ACT_WRITE: begin
                    unique case (reg_sel_t'(in_index_reg))
                        REG_CTRL: begin
                            duty_sel_next       = in_wval_reg[7:6];
                            flags_next.halt     = in_wval_reg[5];
                            flags_next.const_vol = in_wval_reg[4];
                            volume_next         = in_wval_reg[3:0];
                        end
                        REG_SWEEP: begin
                            flags_next.sweep_en     = in_wval_reg[7];
                            flags_next.negate       = in_wval_reg[3];
                            sw_period_next          = in_wval_reg[6:4];
                            sw_shift_next           = in_wval_reg[2:0];
                            flags_next.sweep_reload = 1'b1;
                        end
                        REG_LO: begin
                            period_next[7:0] = in_wval_reg;
                        end
                        REG_HI: begin
                            period_next[10:8]    = in_wval_reg[2:0];
                            flags_next.env_start = 1'b1;
                            duty_step_next       = 3'd0;
                            if (flags_reg.enabled) begin
                                length_next = LENGTH_TABLE[in_wval_reg[7:3]];
                            end
                        end
                    endcase
                end
                ACT_TICK: begin
                    if (countdown_reg == '0) begin
                        countdown_next = period_reg;
                        duty_step_next = duty_step_reg + 3'd1;
                    end else begin
                        countdown_next = countdown_reg - 11'd1;
                    end
                end
                ACT_QUARTER, ACT_HALF: begin
                    // Envelope
                    if (flags_reg.env_start) begin
                        flags_next.env_start = 1'b0;
                        env_div_next         = volume_reg;
                        env_level_next       = ENV_TOP;
                    end else if (env_div_reg == '0) begin
                        env_div_next = volume_reg;
                        if (env_level_reg != '0) begin
                            env_level_next = env_level_reg - 4'd1;
                        end else if (flags_reg.halt) begin
                            env_level_next = ENV_TOP;
                        end
                    end else begin
                        env_div_next = env_div_reg - 4'd1;
                    end

                    if (action_t'(in_action_reg) == ACT_HALF) begin
                        // Length counter
                        if (length_reg != '0 && !flags_reg.halt) begin
                            length_next = length_reg - 8'd1;
                        end
                        // Sweep
                        if (sw_div_reg == '0 && flags_reg.sweep_en && sw_shift_reg != '0) begin
                            if (flags_reg.negate) begin
                                if (period_reg >= PERIOD_MIN) begin
                                    period_next = period_reg - dec;
                                end
                            end else if (!target[11] && period_reg >= PERIOD_MIN) begin
                                period_next = target[10:0];
                            end
                        end
                        if (flags_reg.sweep_reload) begin
                            sw_div_next             = sw_period_reg;
                            flags_next.sweep_reload = 1'b0;
                        end else if (sw_div_reg == '0) begin
                            sw_div_next = sw_period_reg;
                        end else begin
                            sw_div_next = sw_div_reg - 3'd1;
                        end
                    end
                end
                ACT_ENABLE: begin
                    flags_next.enabled = in_en_reg;
                    if (!in_en_reg) begin
                        length_next = '0;
                    end
                end
                default: begin
                    // unused action codes leave the state alone
                end
            endcase
        end
    end

    // Gated output from the post-update state
    logic [3:0] level_next;

    always_comb begin
        logic [11:0] mute_target;
        logic        duty_bit;

        duty_bit    = DUTY_TABLE[duty_sel_next][duty_step_next];
        mute_target = {1'b0, period_next} + {1'b0, period_next >> sw_shift_next};
        if (!duty_bit || (!flags_next.negate && mute_target[11]) ||
            length_next == '0 || period_next < PERIOD_MIN) begin
            level_next = '0;
        end else if (flags_next.const_vol) begin
            level_next = volume_next;
        end else begin
            level_next = env_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= '0;
            period_reg    <= '0;
            duty_step_reg <= '0;
            duty_sel_reg  <= '0;
            length_reg    <= '0;
            volume_reg    <= '0;
            env_div_reg   <= '0;
            env_level_reg <= ENV_TOP;
            sw_shift_reg  <= '0;
            sw_period_reg <= '0;
            sw_div_reg    <= '0;
            flags_reg     <= '0;
        end else begin
            countdown_reg <= countdown_next;
            period_reg    <= period_next;
            duty_step_reg <= duty_step_next;
            duty_sel_reg  <= duty_sel_next;
            length_reg    <= length_next;
            volume_reg    <= volume_next;
            env_div_reg   <= env_div_next;
            env_level_reg <= env_level_next;
            sw_shift_reg  <= sw_shift_next;
            sw_period_reg <= sw_period_next;
            sw_div_reg    <= sw_div_next;
            flags_reg     <= flags_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_level_reg  <= level_next;
            out_length_reg <= (length_next != '0);
            out_on_reg     <= flags_next.enabled;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
`include "square_wave_tone_channel_unit_defines.svh"

    `SWT_ASSERT_NOW(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready, "input taken while pipeline stalled")
    `SWT_ASSERT_NEXT(a_disable_clears_len, advance && in_action_reg == ACT_ENABLE && !in_en_reg, length_reg == '0, "disable did not clear length")
    `SWT_ASSERT_NOW(a_level_needs_length, out_valid_reg && out_level_reg != '0, out_length_reg, "nonzero level with zero length")
    `SWT_ASSERT_NEXT(a_result_follows, advance, out_valid_reg, "processed item produced no result")

endmodule

### test/tb_square_wave_tone_channel_unit.sv
module tb_square_wave_tone_channel_unit;
    import swt_pkg::*;

    localparam int CLK_HIGH        = 10;
    localparam int CLK_LOW         = 10;
    localparam int RESET_CYCLES    = 8;
    // spare cycles waited after the last expected result has come back
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // action codes the block must ignore
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // result fields, lowest bit last
    typedef struct packed {
        logic       chan_on;
        logic       len_on;
        logic [3:0] level;
    } tone_out_t;

    localparam tone_out_t SILENT_OFF = '{chan_on: 1'b0, len_on: 1'b0, level: 4'd0};
    localparam tone_out_t SILENT_ON  = '{chan_on: 1'b1, len_on: 1'b0, level: 4'd0};

    // directed stimulus row; pinned rows carry a hand-typed result
    typedef struct packed {
        logic [2:0] act;
        logic [1:0] idx;
        logic [7:0] val;
        logic       en;
        logic       pinned;
        tone_out_t  want;
    } stim_row_t;

    // waveform of each duty setting, stepped by the sequencer position
    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    // note length loaded by a period-high write, indexed by its top five bits
    localparam logic [7:0] LEN_LOOKUP [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    localparam stim_row_t INTRO_ROWS [25] = '{
        '{ACT_TICK,        REG_CTRL,  8'h00, 1'b0, 1'b1, SILENT_OFF}, // fresh out of reset
        '{ACT_SPARE_LAST,  REG_HI,    8'hFF, 1'b1, 1'b1, SILENT_OFF}, // ignored action
        '{ACT_WRITE,       REG_HI,    8'hFF, 1'b0, 1'b1, SILENT_OFF}, // no length load, off
        '{ACT_ENABLE,      REG_CTRL,  8'h00, 1'b0, 1'b1, SILENT_OFF},
        '{ACT_ENABLE,      REG_CTRL,  8'h00, 1'b1, 1'b1, SILENT_ON},
        '{ACT_WRITE,       REG_CTRL,  8'hFF, 1'b0, 1'b1, SILENT_ON},  // length still zero
        '{ACT_WRITE,       REG_SWEEP, 8'h00, 1'b0, 1'b0, SILENT_OFF}, // shift zero
        '{ACT_WRITE,       REG_LO,    8'hFF, 1'b0, 1'b0, SILENT_OFF},
        '{ACT_WRITE,       REG_HI,    8'h08, 1'b1, 1'b0, SILENT_OFF}, // load 254
        '{ACT_QUARTER,     REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // envelope restart
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // halted length
        '{ACT_WRITE,       REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // duty 0, envelope
        '{ACT_TICK,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // underflow, step
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // length counts down
        '{ACT_WRITE,       REG_SWEEP, 8'h89, 1'b0, 1'b0, SILENT_OFF}, // negate, shift 1
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // period drops
        '{ACT_WRITE,       REG_LO,    8'h05, 1'b0, 1'b0, SILENT_OFF}, // period below 8
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // short period kept
        '{ACT_WRITE,       REG_SWEEP, 8'h81, 1'b0, 1'b0, SILENT_OFF}, // add mode, shift 1
        '{ACT_WRITE,       REG_HI,    8'h0E, 1'b0, 1'b0, SILENT_OFF}, // target past 0x7FF
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF}, // overflow blocks add
        '{ACT_WRITE,       REG_SWEEP, 8'h80, 1'b0, 1'b0, SILENT_OFF}, // enabled, shift zero
        '{ACT_HALF,        REG_CTRL,  8'h00, 1'b0, 1'b0, SILENT_OFF},
        '{ACT_ENABLE,      REG_CTRL,  8'h00, 1'b0, 1'b1, SILENT_OFF}, // clears length
        '{ACT_SPARE_FIRST, REG_CTRL,  8'h00, 1'b0, 1'b1, SILENT_OFF}
    };

    // DUT ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [1:0] reg_index, [9:2] write_value, [10] enable_value
    logic [2:0]  s_axis_tuser;   // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [3:0] level, [4] length_active, [5] channel_on

    // channel state as the predictor sees it
    logic        negate_mode = 1'b0;
    logic [10:0] tmr_count   = '0;
    logic [10:0] tmr_reload  = '0;
    logic [2:0]  seq_pos     = '0;
    logic [1:0]  duty_sel    = '0;
    logic [7:0]  len_cnt     = '0;
    logic [3:0]  vol         = '0;
    logic [3:0]  env_div     = '0;
    logic [3:0]  env_lvl     = ENV_TOP;
    logic [2:0]  swp_shift   = '0;
    logic [2:0]  swp_period  = '0;
    logic [2:0]  swp_div     = '0;
    logic        f_halt      = 1'b0;
    logic        f_const     = 1'b0;
    logic        f_sweep     = 1'b0;
    logic        f_reload    = 1'b0;
    logic        f_negate    = 1'b0;
    logic        f_start     = 1'b0;
    logic        f_enabled   = 1'b0;

    tone_out_t   expected_tones [$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    int          cycles_run  = 0;

    // traffic shaping knobs, flipped by the main sequence
    logic        tx_gaps     = 1'b0;
    logic        rx_stalls   = 1'b0;
    logic        hold_req    = 1'b0;

    square_wave_tone_channel_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HIGH aclk = 1'b1;
        #CLK_LOW  aclk = 1'b0;
    end

    // Envelope clock, shared by quarter- and half-frame events.
    function automatic void clock_envelope();
        if (f_start) begin
            f_start = 1'b0;
            env_div = vol;
            env_lvl = ENV_TOP;
        end else if (env_div == 4'd0) begin
            env_div = vol;
            if (env_lvl != 4'd0)
                env_lvl = env_lvl - 4'd1;
            else if (f_halt)
                env_lvl = ENV_TOP;
        end else begin
            env_div = env_div - 4'd1;
        end
    endfunction

    // Apply one accepted transaction to the channel state and return the
    // tone result the block should produce for it.
    function automatic tone_out_t predict_tone(input logic [2:0] act, input logic [1:0] idx,
                                               input logic [7:0] val, input logic en);
        logic [10:0] change;
        logic [11:0] target;
        tone_out_t   r;

        case (act)
            ACT_WRITE: begin
                case (idx)
                    REG_CTRL: begin
                        duty_sel = val[7:6];
                        f_halt   = val[5];
                        f_const  = val[4];
                        vol      = val[3:0];
                    end
                    REG_SWEEP: begin
                        f_sweep    = val[7];
                        swp_period = val[6:4];
                        f_negate   = val[3];
                        swp_shift  = val[2:0];
                        f_reload   = 1'b1;
                    end
                    REG_LO: tmr_reload[7:0] = val;
                    default: begin
                        tmr_reload[10:8] = val[2:0];
                        f_start = 1'b1;
                        seq_pos = 3'd0;
                        // length only loads while the channel is enabled
                        if (f_enabled)
                            len_cnt = LEN_LOOKUP[val[7:3]];
                    end
                endcase
            end
            ACT_TICK: begin
                if (tmr_count == 11'd0) begin
                    tmr_count = tmr_reload;
                    seq_pos   = seq_pos + 3'd1;
                end else begin
                    tmr_count = tmr_count - 11'd1;
                end
            end
            ACT_QUARTER: clock_envelope();
            ACT_HALF: begin
                // envelope, then length, then sweep
                clock_envelope();
                if (len_cnt != 8'd0 && !f_halt)
                    len_cnt = len_cnt - 8'd1;
                if (swp_div == 3'd0 && f_sweep && swp_shift != 3'd0) begin
                    change = tmr_reload >> swp_shift;
                    if (f_negate) begin
                        // ones-complement mode drops one extra
                        if (tmr_reload >= PERIOD_MIN)
                            tmr_reload = tmr_reload - change - {10'd0, negate_mode};
                    end else begin
                        target = {1'b0, tmr_reload} + {1'b0, change};
                        if (target <= {1'b0, PERIOD_MAX} && tmr_reload >= PERIOD_MIN)
                            tmr_reload = target[10:0];
                    end
                end
                if (f_reload) begin
                    swp_div  = swp_period;
                    f_reload = 1'b0;
                end else if (swp_div == 3'd0) begin
                    swp_div = swp_period;
                end else begin
                    swp_div = swp_div - 3'd1;
                end
            end
            ACT_ENABLE: begin
                f_enabled = en;
                if (!en)
                    len_cnt = 8'd0;
            end
            default: ;
        endcase

        // gating: duty low, add-mode overflow, silent length, short period
        target = f_negate ? 12'd0 : {1'b0, tmr_reload} + {1'b0, tmr_reload >> swp_shift};
        r.chan_on = f_enabled;
        r.len_on  = (len_cnt != 8'd0);
        if (!DUTY_PATTERN[duty_sel][seq_pos] || target > {1'b0, PERIOD_MAX} ||
            len_cnt == 8'd0 || tmr_reload < PERIOD_MIN)
            r.level = 4'd0;
        else
            r.level = f_const ? vol : env_lvl;
        return r;
    endfunction

    // Offer one input transaction; bursts and gaps come from tx_gaps.
    // Valid stays high between back-to-back transactions.
    task automatic send(input logic [2:0] act, input logic [1:0] idx, input logic [7:0] val,
                        input logic en, input logic pinned = 1'b0,
                        input tone_out_t pinned_val = SILENT_OFF);
        tone_out_t predicted;

        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                repeat ($urandom_range(1, 6)) begin
                    @(negedge aclk);
                    s_axis_tvalid = 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {5'd0, en, val, idx};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = predict_tone(act, idx, val, en);
        expected_tones.push_back(pinned ? pinned_val : predicted);
        if (act <= ACT_ENABLE)
            items_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (expected_tones.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Negate-mode register is only touched with the channel pipeline empty.
    task automatic set_negate_mode(input logic mode);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = mode;
        do @(posedge aclk); while (!cfg_ready);
        negate_mode = mode;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Event mix that keeps a note alive: mostly timer ticks, some frame
    // clocks, the odd register rewrite, disable or ignored action.
    task automatic random_event();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 55)
            send(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        else if (pick < 70)
            send(ACT_QUARTER, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        else if (pick < 82)
            send(ACT_HALF, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        else if (pick < 92)
            send(ACT_WRITE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        else if (pick < 97)
            send(ACT_ENABLE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 3) != 0));
        else
            send(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    endtask

    // One note: enable, program all four registers, then play events.
    // Periods lean short so timer ticks actually walk the duty sequence.
    task automatic play_phrase();
        logic [7:0] lo_val;
        logic [2:0] hi_bits;

        lo_val  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 24));
        hi_bits = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
        send(ACT_ENABLE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 9) != 0));
        send(ACT_WRITE, REG_CTRL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send(ACT_WRITE, REG_SWEEP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send(ACT_WRITE, REG_LO, lo_val, 1'($urandom_range(0, 1)));
        send(ACT_WRITE, REG_HI, {5'($urandom_range(0, 31)), hi_bits},
             1'($urandom_range(0, 1)));
        repeat ($urandom_range(8, 40)) random_event();
    endtask

    // Mostly notes, some raw noise of any action code.
    task automatic run_phase(input int count);
        int start;

        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                play_phrase();
            end
        end
    endtask

    // Result side: short random stalls when enabled, plus one long
    // hold-off on request, counted here in cycles.
    initial begin : result_sink
        int stall_left;

        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (!rx_stalls) begin
                m_axis_tready = 1'b1;
            end else if (stall_left != 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 7);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Compare every result transaction against the oldest prediction.
    always @(posedge aclk) begin : check_results
        tone_out_t got;
        tone_out_t want;

        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[5:0];
            if (expected_tones.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
            end else begin
                want = expected_tones.pop_front();
                if (got.level !== want.level) begin
                    mismatches++;
                    $display("%0t: level expected %0d actual %0d",
                             $time, want.level, got.level);
                end
                if (got.len_on !== want.len_on) begin
                    mismatches++;
                    $display("%0t: length_active expected %0b actual %0b",
                             $time, want.len_on, got.len_on);
                end
                if (got.chan_on !== want.chan_on) begin
                    mismatches++;
                    $display("%0t: channel_on expected %0b actual %0b",
                             $time, want.chan_on, got.chan_on);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("square_wave_tone_channel_unit regression: fail");
        $finish;
    end

    initial begin : main_seq
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_WRITE;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed walk, twos-complement negate as out of reset
        foreach (INTRO_ROWS[i])
            send(INTRO_ROWS[i].act, INTRO_ROWS[i].idx, INTRO_ROWS[i].val, INTRO_ROWS[i].en,
                 INTRO_ROWS[i].pinned, INTRO_ROWS[i].want);

        // ones-complement, no idling either side
        set_negate_mode(1'b1);
        run_phase(300);

        // both sides idling
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_phase(400);

        // long hold-off on the result side while inputs keep coming,
        // so the pipeline fills and backpressures s_axis
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (80) random_event();

        // sender waits for everything outstanding, then back to twos-complement
        drain();
        set_negate_mode(1'b0);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        run_phase(400);

        set_negate_mode(1'b1);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        run_phase(400);

        drain();
        if (mismatches == 0)
            $display("square_wave_tone_channel_unit regression: pass");
        else
            $display("square_wave_tone_channel_unit regression: fail");
        $finish;
    end

endmodule
